### src/hdd_pkg.sv
// ============================================================================
// hdd_pkg
// Shared types and constants for the Huffman delta decoder.
// ============================================================================
package hdd_pkg;

    localparam int unsigned IDX_W   = 9;
    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned COUNT_W = 34;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;

    localparam logic [7:0] DELTA_WRAP = 8'h20;

    typedef enum logic [2:0] {
        K_LOAD  = 3'b001,
        K_START = 3'b010,
        K_BYTE  = 3'b100
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  idx;
        logic [31:0] freq;
        logic [7:0]  dbyte;
    } t_cmd;

    typedef struct packed {
        logic              live;
        logic [FREQ_W-1:0] freq;
        logic [IDX_W-1:0]  one;
        logic [IDX_W-1:0]  zero;
    } t_node;

endpackage

### src/huffman_delta_decoder.sv
// ============================================================================
// huffman_delta_decoder
// Huffman tree builder and bit-serial decoder with modulo-32 delta output.
// ============================================================================
// Frequency loads and start commands build a code tree in a 512-entry node
// memory; compressed bytes are then decoded one bit per cycle while the output
// is not stalled. A byte leaves the queue, walks its 8 bits, stopping early at
// the last value, and then hands off the byte's last value; the walk reads one
// node per cycle while the output is not stalled. A start writes the leaves,
// then for each of the ALPHABET_SIZE-1 merges makes two full scans of the live
// nodes and three writes; bytes queued behind it wait until the tree is done.
// Two items fit in the input queue, so the input stalls only once two items
// wait while the decoder is busy or the output is stalled.
module huffman_delta_decoder #(
    parameter int unsigned ALPHABET_SIZE  = 255,
    parameter int unsigned ACTIVE_SYMBOLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Single configuration register: number of values to decode.
    input  logic        i_cfg_we,
    input  logic [33:0] i_cfg_wdata,
    // Input items.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_symbol_index,
    input  logic [31:0] i_frequency,
    input  logic [7:0]  i_data_byte,
    // Result items.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_value,
    output logic        o_run_last,
    output logic        o_image_done
);

    logic          w_q_valid, w_q_pop;
    hdd_pkg::t_cmd w_q_cmd;

    // The front part drops unused op codes, out-of-range loads and bytes that
    // arrive before any start, and queues everything else in order.
    hdd_front #(
        .ACTIVE_SYMBOLS(ACTIVE_SYMBOLS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_symbol_index (i_symbol_index),
        .i_frequency    (i_frequency),
        .i_data_byte    (i_data_byte),
        .o_q_valid      (w_q_valid),
        .o_q_cmd        (w_q_cmd),
        .i_q_pop        (w_q_pop)
    );

    // The back part owns the frequency table, the node memory and the walk.
    hdd_back #(
        .ALPHABET_SIZE  (ALPHABET_SIZE),
        .ACTIVE_SYMBOLS (ACTIVE_SYMBOLS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_valid    (w_q_valid),
        .i_q_cmd      (w_q_cmd),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_run_last   (o_run_last),
        .o_image_done (o_image_done)
    );

endmodule

### src/hdd_front.sv
// ============================================================================
// hdd_front
// Accepts input items, drops the ones that have no effect, and queues the rest.
// ============================================================================
module hdd_front #(
    parameter int unsigned ACTIVE_SYMBOLS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [1:0]    i_op,
    input  logic [4:0]    i_symbol_index,
    input  logic [31:0]   i_frequency,
    input  logic [7:0]    i_data_byte,
    output logic          o_q_valid,
    output hdd_pkg::t_cmd o_q_cmd,
    input  logic          i_q_pop
);

    hdd_pkg::t_cmd r_q [2];
    logic [1:0]    r_cnt, n_cnt;
    logic          r_rd, r_wr;
    logic          r_started;
    logic          w_acc, w_keep, w_push;
    hdd_pkg::t_cmd w_cmd;

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        w_cmd.idx   = i_symbol_index;
        w_cmd.freq  = i_frequency;
        w_cmd.dbyte = i_data_byte;
        w_cmd.kind  = hdd_pkg::K_LOAD;
        w_keep      = 1'b0;
        case (i_op)
            hdd_pkg::OP_LOAD: begin
                w_cmd.kind = hdd_pkg::K_LOAD;
                w_keep     = ({1'b0, i_symbol_index} < 6'(ACTIVE_SYMBOLS));
            end
            hdd_pkg::OP_START: begin
                w_cmd.kind = hdd_pkg::K_START;
                w_keep     = 1'b1;
            end
            hdd_pkg::OP_BYTE: begin
                w_cmd.kind = hdd_pkg::K_BYTE;
                w_keep     = r_started;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign w_push    = w_acc && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 2'd0;
            r_rd      <= 1'b0;
            r_wr      <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (i_q_pop) begin
                r_rd <= !r_rd;
            end
            if (w_acc && i_op == hdd_pkg::OP_START) begin
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

### src/hdd_back.sv
// ============================================================================
// hdd_back
// Builds the code tree in the node memory and walks it one bit per cycle while the output is not stalled.
// ============================================================================
module hdd_back #(
    parameter int unsigned ALPHABET_SIZE  = 255,
    parameter int unsigned ACTIVE_SYMBOLS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hdd_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                         i_q_valid,
    input  hdd_pkg::t_cmd                i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_value,
    output logic                         o_run_last,
    output logic                         o_image_done
);

    localparam int unsigned IW   = hdd_pkg::IDX_W;
    localparam int unsigned FW   = hdd_pkg::FREQ_W;
    localparam int unsigned CW   = hdd_pkg::COUNT_W;
    localparam int unsigned FI_W = $clog2(ACTIVE_SYMBOLS);
    localparam logic [IW-1:0] ALPH      = IW'(ALPHABET_SIZE);
    localparam logic [IW-1:0] LAST_LEAF = IW'(ALPHABET_SIZE - 1);
    localparam logic [IW-1:0] LAST_MRG  = IW'(ALPHABET_SIZE - 2);
    localparam logic [IW-1:0] ACT       = IW'(ACTIVE_SYMBOLS);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LEAF   = 8'b0000_0010,
        ST_SCAN   = 8'b0000_0100,
        ST_KILL   = 8'b0000_1000,
        ST_MERGE  = 8'b0001_0000,
        ST_SETTLE = 8'b0010_0000,
        ST_WALK   = 8'b0100_0000,
        ST_FLUSH  = 8'b1000_0000
    } t_state;

    hdd_pkg::t_node mem [2**IW];

    t_state         r_state;
    logic [FW-1:0]  r_ftab [ACTIVE_SYMBOLS];
    logic [CW-1:0]  r_count, r_emit;
    logic [IW-1:0]  r_li, r_total, r_mc, r_sa, r_sel, r_a, r_root, r_walk, n_walk;
    logic           r_svld, r_first;
    hdd_pkg::t_node r_sd, r_wd;
    logic [FW-1:0]  r_best, r_fa;
    logic [2*IW-1:0] r_selc;
    logic [7:0]     r_byte, r_prev, r_pval;
    logic [2:0]     r_bit;
    logic           r_pv, r_pdone;
    logic           r_ov, r_orl, r_oid;
    logic [7:0]     r_oval;

    logic           w_we;
    logic [IW-1:0]  w_waddr;
    hdd_pkg::t_node w_wdata;
    logic           w_free, w_bitv, w_leaf, w_done, w_oload;
    logic [IW-1:0]  w_nxt;
    logic [7:0]     w_sum, w_v;

    assign w_free = !r_ov || !i_out_stall;
    assign w_bitv = r_byte[r_bit];
    assign w_nxt  = w_bitv ? r_wd.one : r_wd.zero;
    assign w_leaf = (w_nxt < ALPH);
    assign w_sum  = r_prev + w_nxt[7:0];
    assign w_v    = (w_sum >= hdd_pkg::DELTA_WRAP) ? (w_sum - hdd_pkg::DELTA_WRAP) : w_sum;
    assign w_done = ((r_emit + CW'(1)) == r_count);

    // The output register takes the held value when a new leaf pushes it out
    // or when the byte is finished.
    assign w_oload = r_pv && w_free &&
                     ((r_state == ST_WALK && r_emit < r_count && w_leaf) ||
                      (r_state == ST_FLUSH));

    assign o_q_pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_out_valid  = r_ov;
    assign o_value      = r_oval;
    assign o_run_last   = r_orl;
    assign o_image_done = r_oid;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_li;
        w_wdata = '0;
        n_walk  = r_walk;
        case (r_state)
            ST_LEAF: begin
                w_we         = 1'b1;
                w_waddr      = r_li;
                w_wdata.live = 1'b1;
                w_wdata.freq = (r_li < ACT) ? r_ftab[r_li[FI_W-1:0]] : '0;
            end
            ST_KILL: begin
                w_we    = 1'b1;
                w_waddr = r_sel;
                w_wdata = {1'b0, r_best, r_selc};
            end
            ST_MERGE: begin
                w_we    = 1'b1;
                w_waddr = r_total;
                w_wdata = {1'b1, r_fa + r_best, r_a, r_sel};
                if (r_mc == LAST_MRG) begin
                    n_walk = r_total;
                end
            end
            ST_WALK: begin
                if (w_free && r_emit < r_count) begin
                    n_walk = w_leaf ? r_root : w_nxt;
                end
            end
            default: begin
                n_walk = r_walk;
            end
        endcase
    end

    // Node memory: one write port, scan read port, walk read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_sd <= mem[r_sa];
        r_wd <= mem[n_walk];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= CW'(1);
            r_emit  <= '0;
            r_prev  <= '0;
            r_walk  <= '0;
            r_root  <= '0;
            r_total <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_svld  <= 1'b0;
            for (int i = 0; i < int'(ACTIVE_SYMBOLS); i++) begin
                r_ftab[i] <= '0;
            end
        end else begin
            r_walk <= n_walk;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_cmd.kind)
                            hdd_pkg::K_LOAD: begin
                                r_ftab[i_q_cmd.idx[FI_W-1:0]] <= i_q_cmd.freq;
                            end
                            hdd_pkg::K_START: begin
                                r_li    <= '0;
                                r_prev  <= '0;
                                r_emit  <= '0;
                                r_state <= ST_LEAF;
                            end
                            hdd_pkg::K_BYTE: begin
                                r_byte  <= i_q_cmd.dbyte;
                                r_bit   <= 3'd7;
                                r_state <= ST_WALK;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LEAF: begin
                    r_li <= r_li + IW'(1);
                    if (r_li == LAST_LEAF) begin
                        r_total <= ALPH;
                        r_mc    <= '0;
                        r_first <= 1'b1;
                        r_sa    <= '0;
                        r_svld  <= 1'b0;
                        r_best  <= '1;
                        r_sel   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Last node of least frequency wins on ties.
                    if (r_svld && r_sd.live && r_sd.freq <= r_best) begin
                        r_best <= r_sd.freq;
                        r_sel  <= r_sa - IW'(1);
                        r_selc <= {r_sd.one, r_sd.zero};
                    end
                    if (r_sa != r_total) begin
                        r_sa   <= r_sa + IW'(1);
                        r_svld <= 1'b1;
                    end else begin
                        r_svld <= 1'b0;
                        if (!r_svld) begin
                            r_state <= ST_KILL;
                        end
                    end
                end
                ST_KILL: begin
                    if (r_first) begin
                        r_a     <= r_sel;
                        r_fa    <= r_best;
                        r_first <= 1'b0;
                        r_sa    <= '0;
                        r_svld  <= 1'b0;
                        r_best  <= '1;
                        r_sel   <= '0;
                        r_state <= ST_SCAN;
                    end else begin
                        r_state <= ST_MERGE;
                    end
                end
                ST_MERGE: begin
                    r_total <= r_total + IW'(1);
                    r_mc    <= r_mc + IW'(1);
                    if (r_mc == LAST_MRG) begin
                        r_root  <= r_total;
                        r_state <= ST_SETTLE;
                    end else begin
                        r_first <= 1'b1;
                        r_sa    <= '0;
                        r_svld  <= 1'b0;
                        r_best  <= '1;
                        r_sel   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SETTLE: begin
                    r_state <= ST_IDLE;
                end
                ST_WALK: begin
                    if (r_emit >= r_count) begin
                        r_state <= ST_FLUSH;
                    end else if (w_free) begin
                        if (w_leaf) begin
                            if (r_pv) begin
                                r_oval <= r_pval;
                                r_orl  <= 1'b0;
                                r_oid  <= r_pdone;
                            end
                            r_pv    <= 1'b1;
                            r_pval  <= w_v;
                            r_pdone <= w_done;
                            r_prev  <= w_v;
                            r_emit  <= r_emit + CW'(1);
                        end
                        if ((w_leaf && w_done) || r_bit == 3'd0) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_bit <= r_bit - 3'd1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pv) begin
                        r_state <= ST_IDLE;
                    end else if (w_free) begin
                        r_oval  <= r_pval;
                        r_orl   <= 1'b1;
                        r_oid   <= r_pdone;
                        r_pv    <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_IDLE && r_pv))
        else $error("value left pending while idle");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= IW'(2 * ALPHABET_SIZE - 1))
        else $error("node count out of range");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_sa <= r_total))
        else $error("scan address past node count");
    a_merge_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |=> (r_total == $past(r_total) + IW'(1)))
        else $error("merge did not append a node");
`endif

endmodule
